>>> rtl/textured_rect_clipper_assert.svh
// ---------------------------------------------------------------------------
// textured rect clipper assertion macros
// concurrent checks on the clipper pipeline, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef TEXTURED_RECT_CLIPPER_ASSERT_SVH
`define TEXTURED_RECT_CLIPPER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trc check failed");

// next-cycle implication
`define TRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trc check failed");

`else

`define TRC_ASSERT_IMP(lbl, ante, cons)
`define TRC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/trc_pkg.sv
// ---------------------------------------------------------------------------
// trc_pkg
// widths, field offsets and pipeline types of the textured rect clipper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

    localparam int COORD_W    = 20;
    localparam int SIZE_W     = COORD_W - 1;
    localparam int TEX_W      = 17;
    localparam int PROD_W     = SIZE_W + TEX_W;
    localparam int NUM_LANES  = 4;
    localparam int DIV_STAGES = TEX_W;
    localparam int CFG_IDX_W  = 2;

    // lanes, in field order
    localparam int LANE_S_START = 0;
    localparam int LANE_T_START = 1;
    localparam int LANE_S_END   = 2;
    localparam int LANE_T_END   = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

    // tdata layout, same on both sides
    localparam int OFF_X    = 0;
    localparam int OFF_Y    = OFF_X + COORD_W;
    localparam int OFF_W    = OFF_Y + COORD_W;
    localparam int OFF_H    = OFF_W + SIZE_W;
    localparam int OFF_TEX  = OFF_H + SIZE_W;
    localparam int DATA_BITS = OFF_TEX + NUM_LANES * TEX_W;
    localparam int TDATA_W  = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - DATA_BITS;

    typedef struct packed {
        logic                      culled;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } geom_t;

    typedef struct packed {
        logic [SIZE_W-1:0]       edge_dist;
        logic [TEX_W-1:0]        mag;
        logic                    neg;
        logic signed [TEX_W-1:0] c;
        logic [SIZE_W-1:0]       d;
    } lane_a_t;

    typedef struct packed {
        logic [SIZE_W-1:0]       r;
        logic [TEX_W-1:0]        nq;
        logic [SIZE_W-1:0]       d;
        logic signed [TEX_W-1:0] c;
        logic                    neg;
    } lane_div_t;

endpackage

`default_nettype wire

>>> rtl/textured_rect_clipper.sv
// ---------------------------------------------------------------------------
// textured_rect_clipper
// clips a textured rectangle to a clip window, texture coords interpolated
// ---------------------------------------------------------------------------
//  channel  dir  signals                       meaning
//  s        in   s_tvalid s_tready s_tdata     rectangle request
//  m        out  m_tvalid m_tready m_tdata     clipped rectangle
//                m_tuser                       culled flag
//  cfg      in   cfg_we cfg_index cfg_data     clip window registers
//
//  one request per cycle while the output does not stall; decode, multiply, 17 stages
//  of restoring division (one quotient bit per stage), output register
//  each stage has its own valid bit and loads when it is empty or its
//  successor loads, so bubbles close up under a stall
//  reset clears the valid bits and the clip window to zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "textured_rect_clipper_assert.svh"

module textured_rect_clipper (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, size_w, size_h, tex_s_start, tex_t_start,
    // tex_s_end, tex_t_end, zero pad
    input  wire  [trc_pkg::TDATA_W-1:0]          s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // out_x, out_y, out_w, out_h, out_s_start, out_t_start,
    // out_s_end, out_t_end, zero pad
    output logic [trc_pkg::TDATA_W-1:0]          m_tdata,
    // culled
    output logic [0:0]                           m_tuser,
    input  wire                                  cfg_we,
    input  wire  [trc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [trc_pkg::COORD_W-1:0]          cfg_data
);

    localparam int CW = trc_pkg::COORD_W;
    localparam int SW = trc_pkg::SIZE_W;
    localparam int TW = trc_pkg::TEX_W;
    localparam int NL = trc_pkg::NUM_LANES;
    localparam int DS = trc_pkg::DIV_STAGES;

    // clip window
    logic signed [CW-1:0] left_reg, top_reg, right_reg, bottom_reg;

    // pipeline registers
    logic                                  a_v_reg;
    trc_pkg::geom_t                        a_geom_reg, a_geom_next;
    trc_pkg::lane_a_t [NL-1:0]             a_lane_reg, a_lane_next;
    logic                                  b_v_reg;
    trc_pkg::geom_t                        b_geom_reg;
    trc_pkg::lane_div_t [NL-1:0]           b_lane_reg, b_lane_next;
    logic [DS-1:0]                         d_v_reg;
    trc_pkg::geom_t                        d_geom_reg [DS];
    trc_pkg::lane_div_t [NL-1:0]           d_lane_reg [DS];
    trc_pkg::lane_div_t [NL-1:0]           d_lane_next [DS];
    logic                                  o_v_reg;
    trc_pkg::geom_t                        o_geom_reg;
    logic [NL-1:0][TW-1:0]                 o_tex_reg, o_tex_next;

    // stage enables
    logic          a_en, b_en, o_en;
    logic [DS-1:0] d_en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trc_pkg::REG_CLIP_LEFT:   left_reg   <= cfg_data;
                trc_pkg::REG_CLIP_TOP:    top_reg    <= cfg_data;
                trc_pkg::REG_CLIP_RIGHT:  right_reg  <= cfg_data;
                trc_pkg::REG_CLIP_BOTTOM: bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // enable chain from the output backwards
    always_comb
    begin
        o_en         = !o_v_reg || m_tready;
        d_en[DS-1]   = !d_v_reg[DS-1] || o_en;
        for (int i = DS - 2; i >= 0; i--)
        begin
            d_en[i] = !d_v_reg[i] || d_en[i+1];
        end
        b_en     = !b_v_reg || d_en[0];
        a_en     = !a_v_reg || b_en;
        s_tready = a_en;
    end

    // decode: window tests, new edges and interpolation operands
    always_comb
    begin
        logic signed [CW-1:0] in_x, in_y;
        logic [SW-1:0]        in_w, in_h;
        logic signed [TW-1:0] tex [NL];
        logic signed [CW:0]   x_e, y_e, rgt_e, bot_e;
        logic signed [CW:0]   wl_e, wt_e, wr_e, wb_e;
        logic signed [CW:0]   dl_e, dr_e, dt_e, db_e, ox_e, oy_e, owr_e, ohb_e;
        logic                 win_en, cull, clip_l, clip_r, clip_t, clip_b;
        logic [SW-1:0]        edge_dist [NL];
        logic signed [TW:0]   diff;
        logic [TW:0]          mag_e;
        integer               other;

        in_x = s_tdata[trc_pkg::OFF_X +: CW];
        in_y = s_tdata[trc_pkg::OFF_Y +: CW];
        in_w = s_tdata[trc_pkg::OFF_W +: SW];
        in_h = s_tdata[trc_pkg::OFF_H +: SW];
        for (int l = 0; l < NL; l++)
        begin
            tex[l] = s_tdata[trc_pkg::OFF_TEX + l*TW +: TW];
        end

        x_e   = {in_x[CW-1], in_x};
        y_e   = {in_y[CW-1], in_y};
        rgt_e = x_e + $signed({2'b00, in_w});
        bot_e = y_e + $signed({2'b00, in_h});
        wl_e  = {left_reg[CW-1], left_reg};
        wt_e  = {top_reg[CW-1], top_reg};
        wr_e  = {right_reg[CW-1], right_reg};
        wb_e  = {bottom_reg[CW-1], bottom_reg};

        win_en = (wr_e > wl_e) && (wb_e > wt_e);
        cull   = win_en && ((rgt_e <= wl_e) || (x_e >= wr_e) ||
                            (bot_e <= wt_e) || (y_e >= wb_e));
        clip_l = win_en && !cull && (x_e < wl_e);
        clip_r = win_en && !cull && (rgt_e > wr_e);
        clip_t = win_en && !cull && (y_e < wt_e);
        clip_b = win_en && !cull && (bot_e > wb_e);

        dl_e  = wl_e - x_e;
        dr_e  = rgt_e - wr_e;
        dt_e  = wt_e - y_e;
        db_e  = bot_e - wb_e;
        ox_e  = clip_l ? wl_e : x_e;
        oy_e  = clip_t ? wt_e : y_e;
        owr_e = wr_e - ox_e;
        ohb_e = wb_e - oy_e;

        // new geometry
        a_geom_next.culled = cull;
        if (cull)
        begin
            a_geom_next.x = '0;
            a_geom_next.y = '0;
            a_geom_next.w = '0;
            a_geom_next.h = '0;
        end
        else
        begin
            a_geom_next.x = ox_e[CW-1:0];
            a_geom_next.y = oy_e[CW-1:0];
            a_geom_next.w = clip_r ? owr_e[SW-1:0] :
                            clip_l ? (in_w - dl_e[SW-1:0]) : in_w;
            a_geom_next.h = clip_b ? ohb_e[SW-1:0] :
                            clip_t ? (in_h - dt_e[SW-1:0]) : in_h;
        end

        edge_dist[trc_pkg::LANE_S_START] = clip_l ? dl_e[SW-1:0] : '0;
        edge_dist[trc_pkg::LANE_T_START] = clip_t ? dt_e[SW-1:0] : '0;
        edge_dist[trc_pkg::LANE_S_END]   = clip_r ? dr_e[SW-1:0] : '0;
        edge_dist[trc_pkg::LANE_T_END]   = clip_b ? db_e[SW-1:0] : '0;

        // lane operands: start pairs with end of the same axis
        // an unclipped lane divides zero by all ones, so its quotient stays zero
        for (int l = 0; l < NL; l++)
        begin
            other = (l + 2) % NL;
            diff  = {tex[other][TW-1], tex[other]} - {tex[l][TW-1], tex[l]};
            mag_e = diff[TW] ? (~diff + 1'b1) : diff;
            a_lane_next[l].edge_dist = edge_dist[l];
            a_lane_next[l].mag  = mag_e[TW-1:0];
            a_lane_next[l].neg  = diff[TW];
            a_lane_next[l].c    = tex[l];
            if (edge_dist[l] == '0)
            begin
                a_lane_next[l].d = '1;
            end
            else
            begin
                a_lane_next[l].d = (l == trc_pkg::LANE_S_START ||
                                    l == trc_pkg::LANE_S_END) ? in_w : in_h;
            end
        end
    end

    // multiply: distance times texture span, split for the divider
    always_comb
    begin
        logic [trc_pkg::PROD_W-1:0] prod;
        for (int l = 0; l < NL; l++)
        begin
            prod = a_lane_reg[l].edge_dist * a_lane_reg[l].mag;
            b_lane_next[l].r   = prod[trc_pkg::PROD_W-1:TW];
            b_lane_next[l].nq  = prod[TW-1:0];
            b_lane_next[l].d   = a_lane_reg[l].d;
            b_lane_next[l].c   = a_lane_reg[l].c;
            b_lane_next[l].neg = a_lane_reg[l].neg;
        end
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        trc_pkg::lane_div_t src;
        logic [SW:0]        trial, diffv;
        logic               ge;
        for (int i = 0; i < DS; i++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                src   = (i == 0) ? b_lane_reg[l] : d_lane_reg[(i == 0) ? 0 : i - 1][l];
                trial = {src.r, src.nq[TW-1]};
                ge    = trial >= {1'b0, src.d};
                diffv = trial - {1'b0, src.d};
                d_lane_next[i][l]    = src;
                d_lane_next[i][l].r  = ge ? diffv[SW-1:0] : trial[SW-1:0];
                d_lane_next[i][l].nq = {src.nq[TW-2:0], ge};
            end
        end
    end

    // apply quotient with its sign, zero for a culled rectangle
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (d_geom_reg[DS-1].culled)
            begin
                o_tex_next[l] = '0;
            end
            else if (d_lane_reg[DS-1][l].neg)
            begin
                o_tex_next[l] = d_lane_reg[DS-1][l].c - d_lane_reg[DS-1][l].nq;
            end
            else
            begin
                o_tex_next[l] = d_lane_reg[DS-1][l].c + d_lane_reg[DS-1][l].nq;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            d_v_reg <= '0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_v_reg <= s_tvalid;
            end
            if (b_en)
            begin
                b_v_reg <= a_v_reg;
            end
            for (int i = 0; i < DS; i++)
            begin
                if (d_en[i])
                begin
                    d_v_reg[i] <= (i == 0) ? b_v_reg : d_v_reg[(i == 0) ? 0 : i - 1];
                end
            end
            if (o_en)
            begin
                o_v_reg <= d_v_reg[DS-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_geom_reg <= a_geom_next;
            a_lane_reg <= a_lane_next;
        end
        if (b_en)
        begin
            b_geom_reg <= a_geom_reg;
            b_lane_reg <= b_lane_next;
        end
        for (int i = 0; i < DS; i++)
        begin
            if (d_en[i])
            begin
                d_geom_reg[i] <= (i == 0) ? b_geom_reg : d_geom_reg[(i == 0) ? 0 : i - 1];
                d_lane_reg[i] <= d_lane_next[i];
            end
        end
        if (o_en)
        begin
            o_geom_reg <= d_geom_reg[DS-1];
            o_tex_reg  <= o_tex_next;
        end
    end

    // output port
    assign m_tvalid = o_v_reg;
    assign m_tuser  = o_geom_reg.culled;
    assign m_tdata  = {{trc_pkg::PAD_W{1'b0}}, o_tex_reg,
                       o_geom_reg.h, o_geom_reg.w, o_geom_reg.y, o_geom_reg.x};

    // checks
    `TRC_ASSERT_IMP(a_culled_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    `TRC_ASSERT_IMP(a_ready_when_empty, !a_v_reg, s_tready)
    `TRC_ASSERT_NXT(a_decode_moves, a_v_reg && b_en, b_v_reg)
    `TRC_ASSERT_IMP(a_rem_bound, d_v_reg[DS-1] && !d_geom_reg[DS-1].culled && (d_lane_reg[DS-1][0].d != '0), d_lane_reg[DS-1][0].r < d_lane_reg[DS-1][0].d)

endmodule

`default_nettype wire

>>> bench/tb_textured_rect_clipper.sv
// ---------------------------------------------------------------------------
// tb_textured_rect_clipper
// self-checking bench: clip windows are swept through empty, small, offset
// and full-range settings; rectangles go in as bursts with random gaps while
// the output side stalls on its own pattern, and every clipped rectangle is
// compared field by field with a local prediction of the clip
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_textured_rect_clipper;

    localparam int COORD_W      = trc_pkg::COORD_W;
    localparam int SIZE_W       = trc_pkg::SIZE_W;
    localparam int TEX_W        = trc_pkg::TEX_W;
    localparam int CFG_IDX_W    = trc_pkg::CFG_IDX_W;
    localparam int TDATA_W      = trc_pkg::TDATA_W;
    localparam int OFF_X        = trc_pkg::OFF_X;
    localparam int OFF_Y        = trc_pkg::OFF_Y;
    localparam int OFF_W        = trc_pkg::OFF_W;
    localparam int OFF_H        = trc_pkg::OFF_H;
    localparam int OFF_TEX      = trc_pkg::OFF_TEX;
    localparam int LANE_S_START = trc_pkg::LANE_S_START;
    localparam int LANE_T_START = trc_pkg::LANE_T_START;
    localparam int LANE_S_END   = trc_pkg::LANE_S_END;
    localparam int LANE_T_END   = trc_pkg::LANE_T_END;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = trc_pkg::REG_CLIP_LEFT;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = trc_pkg::REG_CLIP_TOP;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = trc_pkg::REG_CLIP_RIGHT;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = trc_pkg::REG_CLIP_BOTTOM;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic signed [TEX_W-1:0]   s1;
        logic signed [TEX_W-1:0]   t1;
        logic signed [TEX_W-1:0]   s2;
        logic signed [TEX_W-1:0]   t2;
    } rect_t;

    typedef struct {
        logic  culled;
        rect_t r;
    } clipped_t;

    // scoreboard: predicts the clip of each accepted request
    class clip_scoreboard;
        longint   win_l, win_t, win_r, win_b;
        clipped_t pending[$];
        int       errors;

        function new();
            win_l = 0; win_t = 0; win_r = 0; win_b = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic signed [COORD_W-1:0] v);
            case (idx)
                REG_CLIP_LEFT:   win_l = v;
                REG_CLIP_TOP:    win_t = v;
                REG_CLIP_RIGHT:  win_r = v;
                REG_CLIP_BOTTOM: win_b = v;
                default: ;
            endcase
        endfunction

        // c moved towards other by moved/size of the span, truncated to zero
        function longint tex_lerp(longint c, longint other, longint moved, longint span);
            longint diff;
            longint mag;
            longint q;
            diff = other - c;
            mag = (diff < 0) ? -diff : diff;
            if (span <= 0 || moved <= 0)
                return c;
            q = (moved * mag) / span;
            return (diff < 0) ? c - q : c + q;
        endfunction

        function void note_request(rect_t r);
            clipped_t e;
            longint x, y, w, h, rt, bt, ox, oy, ow, oh;
            longint os1, ot1, os2, ot2;
            x = r.x; y = r.y; w = r.w; h = r.h;
            ox = x; oy = y; ow = w; oh = h;
            os1 = r.s1; ot1 = r.t1; os2 = r.s2; ot2 = r.t2;
            e.culled = 1'b0;
            if (win_r > win_l && win_b > win_t) begin
                rt = x + w;
                bt = y + h;
                if (rt <= win_l || x >= win_r || bt <= win_t || y >= win_b) begin
                    e.culled = 1'b1;
                    ox = 0; oy = 0; ow = 0; oh = 0;
                    os1 = 0; ot1 = 0; os2 = 0; ot2 = 0;
                end
                else begin
                    // left before right and top before bottom, all from the original edges
                    if (x < win_l) begin
                        os1 = tex_lerp(r.s1, r.s2, win_l - x, w);
                        ox = win_l;
                        ow = w - (win_l - x);
                    end
                    if (rt > win_r) begin
                        os2 = tex_lerp(r.s2, r.s1, rt - win_r, w);
                        ow = win_r - ox;
                    end
                    if (y < win_t) begin
                        ot1 = tex_lerp(r.t1, r.t2, win_t - y, h);
                        oy = win_t;
                        oh = h - (win_t - y);
                    end
                    if (bt > win_b) begin
                        ot2 = tex_lerp(r.t2, r.t1, bt - win_b, h);
                        oh = win_b - oy;
                    end
                end
            end
            e.r.x = ox[COORD_W-1:0];
            e.r.y = oy[COORD_W-1:0];
            e.r.w = ow[SIZE_W-1:0];
            e.r.h = oh[SIZE_W-1:0];
            e.r.s1 = os1[TEX_W-1:0];
            e.r.t1 = ot1[TEX_W-1:0];
            e.r.s2 = os2[TEX_W-1:0];
            e.r.t2 = ot2[TEX_W-1:0];
            pending.push_back(e);
        endfunction

        function void check_result(logic culled, rect_t r);
            clipped_t e;
            if (pending.size() == 0) begin
                $error("unexpected result: culled %0d x %0d", culled, r.x);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (culled !== e.culled) begin
                $error("culled: expected %0d actual %0d", e.culled, culled); errors++;
            end
            if (r.x !== e.r.x) begin
                $error("out_x: expected %0d actual %0d", e.r.x, r.x); errors++;
            end
            if (r.y !== e.r.y) begin
                $error("out_y: expected %0d actual %0d", e.r.y, r.y); errors++;
            end
            if (r.w !== e.r.w) begin
                $error("out_w: expected %0d actual %0d", e.r.w, r.w); errors++;
            end
            if (r.h !== e.r.h) begin
                $error("out_h: expected %0d actual %0d", e.r.h, r.h); errors++;
            end
            if (r.s1 !== e.r.s1) begin
                $error("out_s_start: expected %0d actual %0d", e.r.s1, r.s1); errors++;
            end
            if (r.t1 !== e.r.t1) begin
                $error("out_t_start: expected %0d actual %0d", e.r.t1, r.t1); errors++;
            end
            if (r.s2 !== e.r.s2) begin
                $error("out_s_end: expected %0d actual %0d", e.r.s2, r.s2); errors++;
            end
            if (r.t2 !== e.r.t2) begin
                $error("out_t_end: expected %0d actual %0d", e.r.t2, r.t2); errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [TDATA_W-1:0]      s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [TDATA_W-1:0]      m_tdata;
    logic [0:0]              m_tuser;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [COORD_W-1:0]      cfg_data = '0;

    clip_scoreboard sb;
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_cnt = 0;

    textured_rect_clipper dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TDATA_W-1:0] pack_rect(rect_t r);
        logic [TDATA_W-1:0] d;
        d = '0;
        d[OFF_X +: COORD_W] = r.x;
        d[OFF_Y +: COORD_W] = r.y;
        d[OFF_W +: SIZE_W] = r.w;
        d[OFF_H +: SIZE_W] = r.h;
        d[OFF_TEX + LANE_S_START*TEX_W +: TEX_W] = r.s1;
        d[OFF_TEX + LANE_T_START*TEX_W +: TEX_W] = r.t1;
        d[OFF_TEX + LANE_S_END*TEX_W +: TEX_W] = r.s2;
        d[OFF_TEX + LANE_T_END*TEX_W +: TEX_W] = r.t2;
        return d;
    endfunction

    function automatic rect_t unpack_rect(logic [TDATA_W-1:0] d);
        rect_t r;
        r.x = d[OFF_X +: COORD_W];
        r.y = d[OFF_Y +: COORD_W];
        r.w = d[OFF_W +: SIZE_W];
        r.h = d[OFF_H +: SIZE_W];
        r.s1 = d[OFF_TEX + LANE_S_START*TEX_W +: TEX_W];
        r.t1 = d[OFF_TEX + LANE_T_START*TEX_W +: TEX_W];
        r.s2 = d[OFF_TEX + LANE_S_END*TEX_W +: TEX_W];
        r.t2 = d[OFF_TEX + LANE_T_END*TEX_W +: TEX_W];
        return r;
    endfunction

    // accepted requests and results
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(unpack_rect(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], unpack_rect(m_tdata));
    end

    // output stall pattern, mode drawn at random from four
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 150 == 149)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= (stall_cnt % 3 == 0);
            2: m_tready <= $urandom_range(0, 1);
            default: m_tready <= (stall_cnt % 16 < 10);
        endcase
    end

    // one request, staying valid across a burst
    task automatic send_rect(rect_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= pack_rect(r);
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic set_window(longint l, longint t, longint r, longint b);
        longint v[4];
        v = '{l, t, r, b};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= v[i][COORD_W-1:0];
            sb.set_reg(i[CFG_IDX_W-1:0], v[i][COORD_W-1:0]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic rect_t mk(longint x, longint y, longint w, longint h,
                                 longint s1, longint t1, longint s2, longint t2);
        rect_t r;
        r.x = x[COORD_W-1:0]; r.y = y[COORD_W-1:0];
        r.w = w[SIZE_W-1:0]; r.h = h[SIZE_W-1:0];
        r.s1 = s1[TEX_W-1:0]; r.t1 = t1[TEX_W-1:0];
        r.s2 = s2[TEX_W-1:0]; r.t2 = t2[TEX_W-1:0];
        return r;
    endfunction

    // coordinate mostly near the window edges, sometimes anywhere
    function automatic longint near_edge(longint lo, longint hi);
        longint span;
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        span = hi - lo;
        if (span < 0) span = 0;
        if (span > 200000) span = 200000;
        if ($urandom_range(0, 1) == 0)
            return lo - 3000 + $urandom_range(0, span + 6000);
        return hi - 3000 + $urandom_range(0, 6000);
    endfunction

    function automatic rect_t rand_rect();
        longint w, h;
        w = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 6000);
        h = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 6000);
        if ($urandom_range(0, 15) == 0) w = 0;
        if ($urandom_range(0, 15) == 0) h = 0;
        return mk(near_edge(sb.win_l, sb.win_r), near_edge(sb.win_t, sb.win_b), w, h,
                  $urandom(), $urandom(), $urandom(), $urandom());
    endfunction

    task automatic random_rects(int n);
        for (int i = 0; i < n; i++)
            send_rect(rand_rect());
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty window after reset: rectangles pass unchanged
        send_rect(mk(-524288, 524287, 524287, 0, -65536, 65535, 65535, -65536));
        send_rect(mk(524287, -524288, 0, 524287, 65535, -65536, -65536, 65535));
        send_rect(mk(0, 0, 100, 100, 1, 2, 3, 4));
        random_rects(60);
        drain();

        // offset window, directed edge cases
        set_window(-1000, -800, 3000, 2000);
        send_rect(mk(0, 0, 500, 500, 10, 20, 4000, 5000));
        send_rect(mk(-2000, 0, 2000, 500, 0, 0, 65535, 100));
        send_rect(mk(2500, 0, 1000, 500, 65535, 0, -65536, 100));
        send_rect(mk(0, -2000, 500, 2000, 0, -65536, 0, 65535));
        send_rect(mk(0, 1500, 500, 1000, 0, 65535, 0, -65536));
        send_rect(mk(-2000, -2000, 6000, 6000, -65536, -65536, 65535, 65535));
        send_rect(mk(-2000, -2000, 6000, 6000, 65535, 65535, -65536, -65536));
        send_rect(mk(-3000, 0, 2000, 500, 1, 2, 3, 4));
        send_rect(mk(3000, 0, 500, 500, 1, 2, 3, 4));
        send_rect(mk(0, -2000, 500, 1200, 1, 2, 3, 4));
        send_rect(mk(0, 2000, 500, 500, 1, 2, 3, 4));
        send_rect(mk(-1500, 0, 0, 500, 1, 2, 3, 4));
        send_rect(mk(0, -1500, 500, 0, 1, 2, 3, 4));
        send_rect(mk(0, 0, 100, 0, 1, 2, 3, 4));
        send_rect(mk(-524288, -524288, 524287, 524287, -65536, 7, 65535, -7));
        send_rect(mk(524287, 524287, 524287, 524287, 5, 5, 5, 5));
        send_rect(mk(-999, -799, 3998, 2798, 100, 200, 300, 400));
        random_rects(70);

        // hold off until every clipped rectangle is back
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        random_rects(20);
        drain();

        // full-range window
        set_window(-524288, -524288, 524287, 524287);
        send_rect(mk(-524288, -524288, 524287, 524287, -65536, -65536, 65535, 65535));
        send_rect(mk(524287, 0, 524287, 100, 0, 0, 65535, 0));
        random_rects(70);
        drain();

        // right equal to left: clipping off
        set_window(100, 100, 100, 500);
        random_rects(50);
        drain();

        // small window
        set_window(0, 0, 64, 64);
        send_rect(mk(-64, -64, 192, 192, -65536, 65535, 65535, -65536));
        random_rects(70);
        drain();

        // one-sided extreme window
        set_window(-524288, 0, 10, 524287);
        random_rects(70);
        drain();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> textured_rect_clipper.f
+incdir+rtl
rtl/trc_pkg.sv
rtl/textured_rect_clipper.sv
bench/tb_textured_rect_clipper.sv
